### src/bbc_pkg.sv
package bbc_pkg;

    localparam int BBC_NUM_BUFFERS = 32;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    localparam logic [2:0] ST_HIT         = 3'd0;
    localparam logic [2:0] ST_MISS        = 3'd1;
    localparam logic [2:0] ST_NO_FREE     = 3'd2;
    localparam logic [2:0] ST_BAD_RELEASE = 3'd3;
    localparam logic [2:0] ST_RELEASED    = 3'd4;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_UPD
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INC,
        OP_RETAG,
        OP_DEC,
        OP_SHIFT
    } op_t;

    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic        valid;
        logic [7:0]  count;
    } bbc_entry_t;

    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [4:0]  bidx;
    } bbc_req_t;

    typedef struct packed {
        op_t  op;
        logic tgt;
        logic shf;
    } bbc_cell_ctl_t;

    typedef struct packed {
        logic hit;
        logic free;
        logic ideq;
    } bbc_flag_t;

endpackage

### src/bbc_cell.sv
module bbc_cell #(
    parameter int IW  = 5,
    parameter int CW  = 5,
    parameter int POS = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bbc_pkg::bbc_req_t     req,
    input  bbc_pkg::bbc_cell_ctl_t ctl,
    input  bbc_pkg::bbc_entry_t   nb_ent,
    input  logic [IW-1:0]         nb_id,
    output bbc_pkg::bbc_entry_t   ent,
    output logic [IW-1:0]         id,
    output bbc_pkg::bbc_flag_t    flag
);

    bbc_pkg::bbc_entry_t ent_reg, ent_next;
    logic [IW-1:0]       id_reg, id_next;
    bbc_pkg::bbc_flag_t  flag_reg, flag_next;

    always_comb begin
        ent_next = ent_reg;
        id_next  = id_reg;
        if (ctl.shf) begin
            ent_next = nb_ent;
            id_next  = nb_id;
        end else if (ctl.tgt) begin
            case (ctl.op)
                bbc_pkg::OP_INC: begin
                    if (ent_reg.count != bbc_pkg::COUNT_MAX) begin
                        ent_next.count = ent_reg.count + 8'd1;
                    end
                end
                bbc_pkg::OP_RETAG: begin
                    ent_next.dev   = req.dev;
                    ent_next.blk   = req.blk;
                    ent_next.valid = 1'b1;
                    ent_next.count = 8'd1;
                end
                bbc_pkg::OP_DEC: begin
                    ent_next.count = ent_reg.count - 8'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        flag_next.hit  = ent_reg.valid && (ent_reg.dev == req.dev) && (ent_reg.blk == req.blk);
        flag_next.free = (ent_reg.count == 8'd0);
        flag_next.ideq = (CW'(id_reg) == CW'(req.bidx));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '0;
            id_reg  <= IW'(POS);
        end else begin
            ent_reg <= ent_next;
            id_reg  <= id_next;
        end
    end

    always_ff @(posedge aclk) begin
        flag_reg <= flag_next;
    end

    assign ent  = ent_reg;
    assign id   = id_reg;
    assign flag = flag_reg;

endmodule

### src/block_buffer_cache_lru_unit.sv
// Buffer cache tag store with reference counts and least recent replacement.
// Input channel s_*: one transaction per command. s_tuser[0] is the command
// (0 get, 1 put); s_tdata carries device, block and buffer index.
// Output channel m_*: one result transaction per command, carrying status,
// granted buffer index and the moved-to-recent flag.
// Buffers sit in a row of cells ordered least recent to most recent; a put
// that frees a buffer shifts the cells above it down by one and places the
// buffer at the most recent end, all at once in the update step.
// Steps per command: tag compare in every cell, victim and target selection,
// cell update with result load.
// The row of cells handles a single command at a time; a new command is
// accepted only in the idle state, after the compare, select and update
// sequence of the previous one has finished.
// A stalled receiver holds the result in the output register; the next
// command is taken meanwhile but waits in its update step until the held
// result leaves.
// Reset: aresetn low clears all tags, counts and in-table bits and restores
// the recency order to buffer 0 least recent; no clearing pass is needed.
module block_buffer_cache_lru_unit #(
    parameter int NUM_BUFFERS = bbc_pkg::BBC_NUM_BUFFERS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // dev_number[7:0], block_number[39:8], buffer_index[44:40]
    input  logic [0:0]  s_tuser,  // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // status[2:0], granted_index[7:3], moved_to_recent[8]
);

    localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CW = (IW > 5) ? IW : 5;

    bbc_pkg::state_t   state_reg, state_next;
    bbc_pkg::bbc_req_t req_reg;
    logic              cmd_reg;

    bbc_pkg::bbc_entry_t    ent     [NUM_BUFFERS];
    logic [IW-1:0]          id      [NUM_BUFFERS];
    bbc_pkg::bbc_flag_t     flag    [NUM_BUFFERS];
    bbc_pkg::bbc_cell_ctl_t ctl     [NUM_BUFFERS];
    bbc_pkg::bbc_entry_t    tail_ent;

    logic [NUM_BUFFERS-1:0] hit_vec, free_vec, ideq_vec;
    logic [NUM_BUFFERS-1:0] free_oh, ge_mask;
    logic [IW-1:0]          hit_id, free_id, put_id;
    logic [7:0]             put_cnt;
    logic [7:0]             put_dev;
    logic [31:0]            put_blk;
    logic                   put_valid;

    logic [NUM_BUFFERS-1:0] hit_vec_reg, free_oh_reg, put_oh_reg, ge_reg;
    logic                   hit_any_reg, free_any_reg, put_found_reg;
    logic [IW-1:0]          hit_id_reg, free_id_reg, put_id_reg;
    logic [7:0]             put_cnt_reg, put_dev_reg;
    logic [31:0]            put_blk_reg;
    logic                   put_valid_reg;

    logic       out_valid_reg, out_valid_next;
    logic [2:0] status_reg, status_next;
    logic [4:0] idx_reg, idx_next;
    logic       moved_reg, moved_next;

    logic       out_free, load;
    bbc_pkg::op_t op;
    logic [NUM_BUFFERS-1:0] tgt_vec, shf_vec;

    assign out_free = !out_valid_reg || m_tready;

    assign tail_ent = '{dev: put_dev_reg, blk: put_blk_reg, valid: put_valid_reg, count: 8'd0};

    genvar g;
    generate
        for (g = 0; g < NUM_BUFFERS; g++) begin : g_cell
            assign ctl[g] = '{op: op, tgt: tgt_vec[g], shf: shf_vec[g]};
            assign hit_vec[g]  = flag[g].hit;
            assign free_vec[g] = flag[g].free;
            assign ideq_vec[g] = flag[g].ideq;
            if (g == NUM_BUFFERS - 1) begin : g_last
                bbc_cell #(.IW(IW), .CW(CW), .POS(g)) u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .req     (req_reg),
                    .ctl     (ctl[g]),
                    .nb_ent  (tail_ent),
                    .nb_id   (put_id_reg),
                    .ent     (ent[g]),
                    .id      (id[g]),
                    .flag    (flag[g])
                );
            end else begin : g_mid
                bbc_cell #(.IW(IW), .CW(CW), .POS(g)) u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .req     (req_reg),
                    .ctl     (ctl[g]),
                    .nb_ent  (ent[g+1]),
                    .nb_id   (id[g+1]),
                    .ent     (ent[g]),
                    .id      (id[g]),
                    .flag    (flag[g])
                );
            end
        end
    endgenerate

    always_comb begin
        free_oh   = free_vec & (~free_vec + NUM_BUFFERS'(1));
        ge_mask   = ~(ideq_vec - NUM_BUFFERS'(1));
        hit_id    = '0;
        free_id   = '0;
        put_id    = '0;
        put_cnt   = '0;
        put_dev   = '0;
        put_blk   = '0;
        put_valid = 1'b0;
        for (int p = 0; p < NUM_BUFFERS; p++) begin
            hit_id    = hit_id  | (id[p] & {IW{hit_vec[p]}});
            free_id   = free_id | (id[p] & {IW{free_oh[p]}});
            put_id    = put_id  | (id[p] & {IW{ideq_vec[p]}});
            put_cnt   = put_cnt | (ent[p].count & {8{ideq_vec[p]}});
            put_dev   = put_dev | (ent[p].dev & {8{ideq_vec[p]}});
            put_blk   = put_blk | (ent[p].blk & {32{ideq_vec[p]}});
            put_valid = put_valid | (ent[p].valid & ideq_vec[p]);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == bbc_pkg::S_SEL) begin
            hit_vec_reg   <= hit_vec;
            hit_any_reg   <= |hit_vec;
            hit_id_reg    <= hit_id;
            free_oh_reg   <= free_oh;
            free_any_reg  <= |free_vec;
            free_id_reg   <= free_id;
            put_oh_reg    <= ideq_vec;
            put_found_reg <= |ideq_vec;
            put_id_reg    <= put_id;
            put_cnt_reg   <= put_cnt;
            put_dev_reg   <= put_dev;
            put_blk_reg   <= put_blk;
            put_valid_reg <= put_valid;
            ge_reg        <= ge_mask;
        end
    end

    always_comb begin
        unique case (state_reg)
            bbc_pkg::S_IDLE: state_next = s_tvalid ? bbc_pkg::S_CMP : bbc_pkg::S_IDLE;
            bbc_pkg::S_CMP:  state_next = bbc_pkg::S_SEL;
            bbc_pkg::S_SEL:  state_next = bbc_pkg::S_UPD;
            bbc_pkg::S_UPD:  state_next = out_free ? bbc_pkg::S_IDLE : bbc_pkg::S_UPD;
            default:         state_next = bbc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == bbc_pkg::S_IDLE);
        load        = (state_reg == bbc_pkg::S_UPD) && out_free;
        op          = bbc_pkg::OP_NONE;
        tgt_vec     = '0;
        shf_vec     = '0;
        status_next = bbc_pkg::ST_NO_FREE;
        idx_next    = 5'd0;
        moved_next  = 1'b0;
        if (cmd_reg == bbc_pkg::CMD_GET) begin
            if (hit_any_reg) begin
                op          = bbc_pkg::OP_INC;
                tgt_vec     = hit_vec_reg;
                status_next = bbc_pkg::ST_HIT;
                idx_next    = 5'(hit_id_reg);
            end else if (free_any_reg) begin
                op          = bbc_pkg::OP_RETAG;
                tgt_vec     = free_oh_reg;
                status_next = bbc_pkg::ST_MISS;
                idx_next    = 5'(free_id_reg);
            end
        end else begin
            idx_next = req_reg.bidx;
            if (!put_found_reg || (put_cnt_reg == 8'd0)) begin
                status_next = bbc_pkg::ST_BAD_RELEASE;
            end else if (put_cnt_reg == 8'd1) begin
                op          = bbc_pkg::OP_SHIFT;
                shf_vec     = ge_reg;
                status_next = bbc_pkg::ST_RELEASED;
                moved_next  = 1'b1;
            end else begin
                op          = bbc_pkg::OP_DEC;
                tgt_vec     = put_oh_reg;
                status_next = bbc_pkg::ST_RELEASED;
            end
        end
        if (!load) begin
            op      = bbc_pkg::OP_NONE;
            tgt_vec = '0;
            shf_vec = '0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bbc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg.dev  <= s_tdata[7:0];
            req_reg.blk  <= s_tdata[39:8];
            req_reg.bidx <= s_tdata[44:40];
            cmd_reg      <= s_tuser[0];
        end
        if (load) begin
            status_reg <= status_next;
            idx_reg    <= idx_next;
            moved_reg  <= moved_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, moved_reg, idx_reg, status_reg};

    a_unique_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbc_pkg::S_UPD) |-> $onehot0(hit_vec_reg))
        else $error("more than one buffer matches the same tag");

    a_onehot_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbc_pkg::S_UPD) |-> $onehot0(free_oh_reg))
        else $error("victim select is not one-hot");

    a_shift_on_last_user: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && op == bbc_pkg::OP_SHIFT) |-> (put_cnt_reg == 8'd1 && put_found_reg))
        else $error("recency shift without the last user releasing");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_tvalid)
        else $error("update step did not present a result");

endmodule
